// File: sv/dcmd_pkg.sv
package dcmd_pkg;

    // Width of the payload fields on the ports.
    localparam int FIELD_BITS = 32;

    // Width of the arithmetic datapath; operands are taken modulo 2^WORD_BITS.
    localparam int WORD_BITS = 32;

    // Restoring divide steps done in each pipeline stage.
    localparam int STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES = (WORD_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // Split of each multiplier operand into a low and a high half.
    localparam int LO_BITS = WORD_BITS / 2;
    localparam int HI_BITS = WORD_BITS - LO_BITS;

    typedef logic [FIELD_BITS-1:0]  field_t;
    typedef logic [WORD_BITS-1:0]   word_t;
    typedef logic [2*WORD_BITS-1:0] dword_t;

    typedef enum logic
    {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } op_t;

    // One request as it arrives on the input channel.
    typedef struct packed
    {
        op_t    operation;
        field_t first_operand;
        field_t second_operand;
        field_t third_operand;
    } req_t;

    // One response as it leaves on the output channel.
    typedef struct packed
    {
        field_t upper_word;
        field_t lower_word;
        logic   divide_by_zero;
        logic   quotient_overflow;
    } rsp_t;

    // Payload that travels down the pipeline. For a divide, hi is the partial
    // remainder and lo collects the quotient; for a multiply they end up
    // holding the product halves.
    typedef struct packed
    {
        op_t   op;
        logic  dz;
        logic  ov;
        word_t d;
        word_t hi;
        word_t lo;
    } rec_t;

    // Per-stage controls, fixed by the stage's place in the pipeline.
    typedef struct packed
    {
        logic                       prod_load;
        logic [STEPS_PER_STAGE-1:0] step_en;
    } stage_ctl_t;

    typedef struct packed
    {
        word_t hi;
        word_t lo;
    } dstep_t;

    // One restoring shift-subtract step. The bit shifted out of the top of
    // the partial remainder forces a subtract.
    function automatic dstep_t div_step(word_t d, word_t hi, word_t lo);
        logic             cy;
        word_t            h;
        word_t            l;
        logic [WORD_BITS:0] diff;
        dstep_t           res;
        cy   = hi[WORD_BITS-1];
        h    = {hi[WORD_BITS-2:0], lo[WORD_BITS-1]};
        l    = {lo[WORD_BITS-2:0], 1'b0};
        diff = {1'b0, h} - {1'b0, d};
        if (cy || !diff[WORD_BITS])
        begin
            h    = diff[WORD_BITS-1:0];
            l[0] = 1'b1;
        end
        res.hi = h;
        res.lo = l;
        return res;
    endfunction

    // Controls of divide stage k: which of its steps are real, and whether
    // it takes in the product of the multiplier.
    function automatic stage_ctl_t stage_ctl(int k);
        stage_ctl_t c;
        c.prod_load = (k == 1);
        for (int j = 0; j < STEPS_PER_STAGE; j++)
        begin
            c.step_en[j] = ((k * STEPS_PER_STAGE + j) < WORD_BITS);
        end
        return c;
    endfunction

endpackage

// File: sv/dcmd_mul.sv
module dcmd_mul import dcmd_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  word_t  a,
    input  word_t  b,
    output dword_t product
);

    logic [2*LO_BITS-1:0]     pp_ll_reg;
    logic [LO_BITS+HI_BITS-1:0] pp_lh_reg;
    logic [LO_BITS+HI_BITS-1:0] pp_hl_reg;
    logic [2*HI_BITS-1:0]     pp_hh_reg;

    // Four half-width partial products, registered.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_ll_reg <= {{LO_BITS{1'b0}}, a[LO_BITS-1:0]}
                       * {{LO_BITS{1'b0}}, b[LO_BITS-1:0]};
            pp_lh_reg <= {{HI_BITS{1'b0}}, a[LO_BITS-1:0]}
                       * {{LO_BITS{1'b0}}, b[WORD_BITS-1:LO_BITS]};
            pp_hl_reg <= {{LO_BITS{1'b0}}, a[WORD_BITS-1:LO_BITS]}
                       * {{HI_BITS{1'b0}}, b[LO_BITS-1:0]};
            pp_hh_reg <= {{HI_BITS{1'b0}}, a[WORD_BITS-1:LO_BITS]}
                       * {{HI_BITS{1'b0}}, b[WORD_BITS-1:LO_BITS]};
        end
    end

    // Sum of the partial products; the cross terms sit one half-word up.
    assign product = {pp_hh_reg, pp_ll_reg}
                   + (dword_t'(pp_lh_reg) << LO_BITS)
                   + (dword_t'(pp_hl_reg) << LO_BITS);

endmodule

// File: sv/dcmd_div_stage.sv
module dcmd_div_stage import dcmd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  stage_ctl_t ctl,
    input  logic       vld_in,
    input  rec_t       rec_in,
    input  dword_t     product,
    output logic       vld_out,
    output rec_t       rec_out
);

    logic   vld_reg;
    rec_t   rec_reg;
    rec_t   rec_next;
    dstep_t st;

    // Divide steps for this stage, or the product load for a multiply.
    always_comb
    begin
        rec_next = rec_in;
        st.hi    = rec_in.hi;
        st.lo    = rec_in.lo;
        if (rec_in.op == OP_DIV && !rec_in.dz)
        begin
            for (int j = 0; j < STEPS_PER_STAGE; j++)
            begin
                if (ctl.step_en[j])
                begin
                    st = div_step(rec_in.d, st.hi, st.lo);
                end
            end
            rec_next.hi = st.hi;
            rec_next.lo = st.lo;
        end
        else if (rec_in.op == OP_MUL && ctl.prod_load)
        begin
            rec_next.hi = product[2*WORD_BITS-1:WORD_BITS];
            rec_next.lo = product[WORD_BITS-1:0];
        end
    end

    // Valid bit travels with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rec_reg <= rec_next;
        end
    end

    assign vld_out = vld_reg;
    assign rec_out = rec_reg;

endmodule

// File: sv/double_cell_mul_div_unit_top.sv
// Double-cell multiply/divide unit. A request is either an unsigned
// WORD_BITS x WORD_BITS multiply giving the full product as high and low
// words, or an unsigned 2*WORD_BITS by WORD_BITS restoring divide giving
// quotient and remainder. A zero divisor returns an all-ones quotient, the
// low dividend word as remainder and divide_by_zero; a high dividend word
// not below the divisor sets quotient_overflow and returns what the
// shift-subtract leaves. The unit accepts one request per clock while no
// response is stalled and passes each request through one input register,
// then DIV_STAGES stages of four restoring steps each, the last of which is
// the output register. The multiply forms its partial products alongside
// the first divide stage and merges into the second. The whole pipeline
// holds while a waiting response is stalled.
module double_cell_mul_div_unit_top import dcmd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic   en;
    logic   in_vld_reg;
    rec_t   in_rec_reg;
    rec_t   in_rec_next;
    word_t  a;
    word_t  b;
    word_t  c;
    dword_t product;

    logic vld_chain [DIV_STAGES+1];
    rec_t rec_chain [DIV_STAGES+1];

    // Pipeline advances unless a finished response is held.
    assign en        = !(vld_chain[DIV_STAGES] && rsp_stall);
    assign req_stall = !en;

    // Input register: operands, flags and start values for the divide.
    always_comb
    begin
        a = word_t'(req.first_operand);
        b = word_t'(req.second_operand);
        c = word_t'(req.third_operand);
        in_rec_next.op = req.operation;
        in_rec_next.dz = (req.operation == OP_DIV) && (a == '0);
        in_rec_next.ov = (req.operation == OP_DIV) && (a != '0) && (b >= a);
        in_rec_next.d  = a;
        if (in_rec_next.dz)
        begin
            in_rec_next.hi = c;
            in_rec_next.lo = '1;
        end
        else
        begin
            in_rec_next.hi = b;
            in_rec_next.lo = c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            in_vld_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_rec_reg <= in_rec_next;
        end
    end

    assign vld_chain[0] = in_vld_reg;
    assign rec_chain[0] = in_rec_reg;

    // Multiplier works from the input register in step with the first stage.
    dcmd_mul u_mul
    (
        .clk     (clk),
        .en      (en),
        .a       (in_rec_reg.d),
        .b       (in_rec_reg.hi),
        .product (product)
    );

    // Divide stages.
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        dcmd_div_stage u_stage
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl     (stage_ctl(k)),
            .vld_in  (vld_chain[k]),
            .rec_in  (rec_chain[k]),
            .product (product),
            .vld_out (vld_chain[k+1]),
            .rec_out (rec_chain[k+1])
        );
    end

    // Response: a divide returns quotient high and remainder low.
    assign rsp_valid = vld_chain[DIV_STAGES];

    always_comb
    begin
        if (rec_chain[DIV_STAGES].op == OP_DIV)
        begin
            rsp.upper_word = field_t'(rec_chain[DIV_STAGES].lo);
            rsp.lower_word = field_t'(rec_chain[DIV_STAGES].hi);
        end
        else
        begin
            rsp.upper_word = field_t'(rec_chain[DIV_STAGES].hi);
            rsp.lower_word = field_t'(rec_chain[DIV_STAGES].lo);
        end
        rsp.divide_by_zero    = rec_chain[DIV_STAGES].dz;
        rsp.quotient_overflow = rec_chain[DIV_STAGES].ov;
    end

endmodule

// File: sv/dcmd_checker.sv
module dcmd_checker import dcmd_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // A stalled response holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // Requests are held back only while a response is waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("request stalled without a waiting response");

    // The two divide flags never come together.
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.divide_by_zero && rsp.quotient_overflow))
        else $error("both divide flags set");

    // A zero divisor gives an all-ones quotient.
    a_dz_quot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.divide_by_zero |-> rsp.upper_word == field_t'(word_t'('1)))
        else $error("zero-divisor quotient is not all ones");

endmodule

bind double_cell_mul_div_unit_top dcmd_checker u_dcmd_checker (.*);
